/* src/slri_pkg.sv */
`timescale 1ns / 1ps

package slri_pkg;

  // payload widths fixed by the item format
  localparam int DATA_WIDTH  = 32;
  localparam int COUNT_WIDTH = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_REMOVED   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic signed [DATA_WIDTH-1:0]  value;
  } in_item_t;

  typedef struct packed {
    status_t                       status;
    logic [COUNT_WIDTH-1:0]        entry_count;
    logic signed [DATA_WIDTH-1:0]  head_value;
    logic                          head_valid;
  } out_item_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert takes effect this cycle
    logic rem;   // remove of a matching entry takes effect this cycle
  } slri_ctrl_t;

endpackage

/* src/slri_cell.sv */
`timescale 1ns / 1ps

module slri_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  slri_pkg::slri_ctrl_t                   ctrl,
  input  logic                                   desc,
  input  logic signed [slri_pkg::DATA_WIDTH-1:0] value,
  input  logic signed [slri_pkg::DATA_WIDTH-1:0] left_entry,
  input  logic                                   left_valid,
  input  logic signed [slri_pkg::DATA_WIDTH-1:0] right_entry,
  input  logic                                   right_valid,
  input  logic                                   pass_in,
  output logic                                   pass_out,
  output logic                                   hit,
  output logic signed [slri_pkg::DATA_WIDTH-1:0] entry,
  output logic                                   valid,
  output logic signed [slri_pkg::DATA_WIDTH-1:0] entry_next,
  output logic                                   valid_next
);
  import slri_pkg::*;

  logic prec;
  logic at_pos;

  // entry sorts strictly before the incoming value
  assign prec = valid && (desc ? (entry > value) : (entry < value));

  // scan stops at the first cell whose entry is not strictly before the value
  assign pass_out = pass_in && prec;
  assign at_pos   = pass_in && !prec;
  assign hit      = at_pos && valid && (entry == value);

  // cells at or past the stop point shift toward tail on insert, head on remove
  always_comb begin
    entry_next = entry;
    valid_next = valid;
    if (ctrl.ins && !pass_out) begin
      entry_next = pass_in ? value : left_entry;
      valid_next = pass_in ? 1'b1 : left_valid;
    end else if (ctrl.rem && !pass_out) begin
      entry_next = right_entry;
      valid_next = right_valid;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

/* src/sorted_list_insert_remove.sv */
`timescale 1ns / 1ps

// Bounded sorted list of signed values held in a row of DEPTH cells, head in
// cell 0. Each transfer on the input either inserts a value (before the first
// entry not strictly before it; dropped when full) or removes the first equal
// entry, and produces one result with status, entry count and head entry.
// Every cell compares against the value at once and a short stop chain runs
// through the row, so an item is resolved combinationally and the result appears
// on the output register the cycle after the input transfer; the block takes
// one item per cycle while the output is not stalled. descending (cfg_we /
// cfg_data) picks the order for later items; stored entries are not reordered.
module sorted_list_insert_remove #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  slri_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output slri_pkg::out_item_t  out_item
);
  import slri_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                         descending;
  logic [CNT_W-1:0]             occupancy;
  logic [CNT_W-1:0]             occupancy_next;
  logic                         fire;
  logic                         full;
  logic                         found;
  slri_ctrl_t                   ctrl;
  status_t                      status;
  logic [DEPTH:0]               pass;
  logic [DEPTH-1:0]             hit_vec;
  logic [DEPTH-1:0]             valid_vec;
  logic [DEPTH-1:0]             valid_next_vec;
  logic signed [DATA_WIDTH-1:0] entry_q      [DEPTH];
  logic signed [DATA_WIDTH-1:0] entry_next_q [DEPTH];
  logic [CNT_W+COUNT_WIDTH-1:0] count_wide;
  out_item_t                    out_item_next;

  // input transfer whenever the output register can take the result
  assign in_stall = out_valid && out_stall;
  assign fire     = in_valid && !in_stall;

  assign full  = (occupancy == CNT_W'(DEPTH));
  assign found = |hit_vec;

  // control broadcast to the cells
  always_comb begin
    ctrl.ins  = fire && (in_item.cmd == CMD_INSERT) && !full;
    ctrl.rem  = fire && (in_item.cmd == CMD_REMOVE) && found;
  end

  // cell row
  assign pass[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_WIDTH-1:0] left_e;
    logic signed [DATA_WIDTH-1:0] right_e;
    logic                         left_v;
    logic                         right_v;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_v = 1'b0;
    end else begin : g_mid_l
      assign left_e = entry_q[i-1];
      assign left_v = valid_vec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_e = entry_q[i+1];
      assign right_v = valid_vec[i+1];
    end

    slri_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .desc        (descending),
      .value       (in_item.value),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .right_entry (right_e),
      .right_valid (right_v),
      .pass_in     (pass[i]),
      .pass_out    (pass[i+1]),
      .hit         (hit_vec[i]),
      .entry       (entry_q[i]),
      .valid       (valid_vec[i]),
      .entry_next  (entry_next_q[i]),
      .valid_next  (valid_next_vec[i])
    );
  end

  // count and status of this item
  always_comb begin
    occupancy_next = occupancy;
    status         = ST_NOT_FOUND;
    if (in_item.cmd == CMD_INSERT) begin
      if (full) begin
        status = ST_DROPPED;
      end else begin
        status         = ST_INSERTED;
        occupancy_next = occupancy + CNT_W'(1);
      end
    end else if (found) begin
      status         = ST_REMOVED;
      occupancy_next = occupancy - CNT_W'(1);
    end
  end

  // result built from the state after this item
  assign count_wide = (CNT_W + COUNT_WIDTH)'(occupancy_next);

  always_comb begin
    out_item_next.status      = status;
    out_item_next.entry_count = count_wide[COUNT_WIDTH-1:0];
    out_item_next.head_valid  = valid_next_vec[0];
    out_item_next.head_value  = valid_next_vec[0] ? entry_next_q[0] : '0;
  end

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_we) begin
      descending <= cfg_data;
    end
  end

  // occupancy counter
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (fire) begin
      occupancy <= occupancy_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= out_item_next;
    end
  end

  // cell flags agree with the counter
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == occupancy)
    else $error("cell valid flags disagree with occupancy");

  // occupied cells form a prefix from the head
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot0(valid_vec ^ (valid_vec >> 1)) && (valid_vec[0] || valid_vec == '0))
    else $error("occupied cells are not contiguous from the head");

  // the scan runs past the tail only when every cell is occupied
  a_pass_full: assert property (@(posedge clk) disable iff (rst)
    pass[DEPTH] |-> full)
    else $error("scan passed every cell of a list that is not full");

  // at most one cell can match on a remove
  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("more than one cell reports a match");

  // a transfer always produces a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted item produced no result");

endmodule
